FILE: src/galois_automorphism_permute_top_defines.svh
// ----------------------------------------------------------------------------
// Galois automorphism permute - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GALOIS_AUTOMORPHISM_PERMUTE_TOP_DEFINES_SVH
`define GALOIS_AUTOMORPHISM_PERMUTE_TOP_DEFINES_SVH

// Same-cycle implication.
`define GAP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap assertion failed");

// Next-cycle implication.
`define GAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap assertion failed");

`endif

FILE: src/gap_pkg.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - package
// Sizes, register codes and shared types of the permute block.
// ----------------------------------------------------------------------------
`default_nettype none

package gap_pkg;

    localparam int LOG_N_MAX       = 12;
    localparam int COEFF_WIDTH     = 61;
    localparam int POS_WIDTH       = LOG_N_MAX;
    localparam int STORE_DEPTH     = 1 << LOG_N_MAX;
    localparam int LOGN_WIDTH      = 4;
    localparam int EFF_WIDTH       = $clog2(LOG_N_MAX + 1);
    localparam int G_WIDTH         = 13;
    localparam int OPND_WIDTH      = POS_WIDTH + 1;
    localparam int PROD_WIDTH      = OPND_WIDTH + G_WIDTH;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LOG_N    = CFG_INDEX_WIDTH'(0),
        CFG_GALOIS   = CFG_INDEX_WIDTH'(1),
        CFG_MODULUS  = CFG_INDEX_WIDTH'(2),
        CFG_NTT_MODE = CFG_INDEX_WIDTH'(3)
    } cfg_reg_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [LOGN_WIDTH-1:0]  log_n;
        logic [G_WIDTH-1:0]     galois_element;
        logic [COEFF_WIDTH-1:0] modulus;
        logic                   ntt_mode;
    } gap_cfg_t;

    typedef struct packed {
        logic                   valid;
        logic                   wr;
        logic [POS_WIDTH-1:0]   addr;
        logic [COEFF_WIDTH-1:0] wdata;
    } gap_access_t;

endpackage

`default_nettype wire

FILE: src/gap_item_if.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - input word channel
// Valid/ready channel carrying one write or read request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gap_item_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [gap_pkg::POS_WIDTH-1:0]   position;
    logic [gap_pkg::COEFF_WIDTH-1:0] coefficient;

    modport source (output valid, output kind, output position, output coefficient,
                    input ready);
    modport sink   (input valid, input kind, input position, input coefficient,
                    output ready);
endinterface

`default_nettype wire

FILE: src/gap_result_if.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - result word channel
// Valid/ready channel carrying one permuted coefficient word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gap_result_if;
    logic                            valid;
    logic                            ready;
    logic [gap_pkg::COEFF_WIDTH-1:0] result_coefficient;

    modport source (output valid, output result_coefficient, input ready);
    modport sink   (input valid, input result_coefficient, output ready);
endinterface

`default_nettype wire

FILE: src/gap_cfg_if.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - configuration write channel
// Valid/ready channel carrying a register index and write data word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gap_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [gap_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [gap_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/gap_index.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - index pipeline
// Two register stages: the masked operand (bit-reversed for reads), then its product
// with the Galois element and the negation, which form the store address and write data.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_index (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            kind,
    input  wire logic [gap_pkg::POS_WIDTH-1:0]   position,
    input  wire logic [gap_pkg::COEFF_WIDTH-1:0] coefficient,
    input  wire gap_pkg::gap_cfg_t               cfg,
    output gap_pkg::gap_access_t                 access
);

    function automatic logic [gap_pkg::POS_WIDTH-1:0] rev_low(
        input logic [gap_pkg::POS_WIDTH-1:0] x,
        input logic [gap_pkg::EFF_WIDTH-1:0] n
    );
        logic [gap_pkg::POS_WIDTH-1:0] r;
        logic [gap_pkg::EFF_WIDTH-1:0] sh;
        for (int i = 0; i < gap_pkg::POS_WIDTH; i++)
        begin
            r[i] = x[gap_pkg::POS_WIDTH-1-i];
        end
        sh = gap_pkg::EFF_WIDTH'(gap_pkg::POS_WIDTH) - n;
        return r >> sh;
    endfunction

    logic [gap_pkg::EFF_WIDTH-1:0]   eff_n;
    logic [gap_pkg::POS_WIDTH-1:0]   nmask;
    logic [gap_pkg::POS_WIDTH-1:0]   pos_m;
    logic [gap_pkg::OPND_WIDTH-1:0]  operand_next;

    logic                            s1_valid_reg;
    logic                            s1_kind_reg;
    logic [gap_pkg::POS_WIDTH-1:0]   s1_pos_reg;
    logic [gap_pkg::COEFF_WIDTH-1:0] s1_coef_reg;
    logic [gap_pkg::OPND_WIDTH-1:0]  s1_operand_reg;

    logic                            s2_valid_reg;
    logic                            s2_kind_reg;
    logic [gap_pkg::POS_WIDTH-1:0]   s2_pos_reg;
    logic [gap_pkg::COEFF_WIDTH-1:0] s2_coef_reg;
    logic [gap_pkg::COEFF_WIDTH-1:0] s2_neg_reg;
    logic [gap_pkg::PROD_WIDTH-1:0]  s2_prod_reg;

    logic [gap_pkg::POS_WIDTH-1:0]   prod_half;
    logic [gap_pkg::POS_WIDTH-1:0]   gather_addr;
    logic [gap_pkg::POS_WIDTH-1:0]   scatter_addr;
    logic                            negate;

    always_comb
    begin
        if (cfg.log_n == '0)
        begin
            eff_n = gap_pkg::EFF_WIDTH'(1);
        end
        else if (int'(cfg.log_n) > gap_pkg::LOG_N_MAX)
        begin
            eff_n = gap_pkg::EFF_WIDTH'(gap_pkg::LOG_N_MAX);
        end
        else
        begin
            eff_n = gap_pkg::EFF_WIDTH'(cfg.log_n);
        end
    end

    assign nmask = {gap_pkg::POS_WIDTH{1'b1}}
                   >> (gap_pkg::EFF_WIDTH'(gap_pkg::POS_WIDTH) - eff_n);
    assign pos_m = position & nmask;
    assign operand_next = (kind == gap_pkg::KIND_READ) ? {rev_low(pos_m, eff_n), 1'b1}
                                                       : {1'b0, pos_m};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg    <= kind;
        s1_pos_reg     <= pos_m;
        s1_coef_reg    <= coefficient;
        s1_operand_reg <= operand_next;

        s2_kind_reg    <= s1_kind_reg;
        s2_pos_reg     <= s1_pos_reg;
        s2_coef_reg    <= s1_coef_reg;
        s2_neg_reg     <= cfg.modulus - s1_coef_reg;
        s2_prod_reg    <= gap_pkg::PROD_WIDTH'(s1_operand_reg)
                          * gap_pkg::PROD_WIDTH'(cfg.galois_element);
    end

    assign prod_half    = s2_prod_reg[gap_pkg::POS_WIDTH:1] & nmask;
    assign gather_addr  = rev_low(prod_half, eff_n);
    assign scatter_addr = s2_prod_reg[gap_pkg::POS_WIDTH-1:0] & nmask;
    assign negate       = s2_prod_reg[eff_n] && (s2_coef_reg != '0);

    always_comb
    begin
        access.valid = s2_valid_reg;
        access.wr    = (s2_kind_reg == gap_pkg::KIND_WRITE);
        access.wdata = s2_coef_reg;
        unique case ({s2_kind_reg, cfg.ntt_mode})
            {gap_pkg::KIND_WRITE, 1'b0}:
            begin
                access.addr  = scatter_addr;
                access.wdata = negate ? s2_neg_reg : s2_coef_reg;
            end
            {gap_pkg::KIND_WRITE, 1'b1}: access.addr = s2_pos_reg;
            {gap_pkg::KIND_READ, 1'b1}:  access.addr = gather_addr;
            default:                     access.addr = s2_pos_reg;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/gap_store.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - coefficient store
// Single-port synchronous memory, one write or one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_store (
    input  wire logic                             clk,
    input  wire gap_pkg::gap_access_t             access,
    output logic [gap_pkg::COEFF_WIDTH-1:0]       rd_data
);

    logic [gap_pkg::COEFF_WIDTH-1:0] mem [gap_pkg::STORE_DEPTH];
    logic [gap_pkg::COEFF_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (access.valid && access.wr)
        begin
            mem[access.addr] <= access.wdata;
        end
        if (access.valid && !access.wr)
        begin
            rd_data_reg <= mem[access.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/gap_out_fifo.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - result queue
// Small register FIFO that decouples store reads from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_out_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic [gap_pkg::COEFF_WIDTH-1:0]    push_data,
    input  wire logic                               pop,
    output logic                                    valid,
    output logic [gap_pkg::COEFF_WIDTH-1:0]         data,
    output logic [gap_pkg::FIFO_CNT_WIDTH-1:0]      count
);

    logic [gap_pkg::COEFF_WIDTH-1:0]    slot_reg [gap_pkg::FIFO_DEPTH];
    logic [gap_pkg::FIFO_PTR_WIDTH-1:0] wr_ptr_reg;
    logic [gap_pkg::FIFO_PTR_WIDTH-1:0] rd_ptr_reg;
    logic [gap_pkg::FIFO_CNT_WIDTH-1:0] count_reg;
    logic [gap_pkg::FIFO_CNT_WIDTH-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign data  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: src/galois_automorphism_permute_top.sv
// ----------------------------------------------------------------------------
// Galois automorphism permute - top level
// Applies X -> X^g to a polynomial held in a coefficient store: write words
// scatter (coefficient mode, with negation) or store in place (NTT mode);
// read words gather the result coefficient (NTT mode) or read in place (coefficient mode).
//
//   channel | dir | payload
//   --------+-----+-----------------------------------------
//   item    | in  | kind, position, coefficient
//   result  | out | result_coefficient
//   cfg     | in  | index, data (log_n, galois_element, modulus, ntt_mode)
//
// One word accepted per cycle while item.ready is high; the single store port takes one access a cycle.
// A read word's result passes the s1 and s2 index stages, the store read register and the result queue.
// Up to eight read results may be in flight or queued; item.ready drops at that.
// Reset clears control and sets configuration to defaults; the store content is not cleared.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "galois_automorphism_permute_top_defines.svh"

module galois_automorphism_permute_top (
    input  wire logic clk,
    input  wire logic rst_n,
    gap_item_if.sink     item,
    gap_result_if.source result,
    gap_cfg_if.sink      cfg
);

    gap_pkg::gap_cfg_t                   cfg_reg;
    gap_pkg::gap_cfg_t                   cfg_next;
    gap_pkg::gap_access_t                access;

    logic [gap_pkg::FIFO_CNT_WIDTH-1:0]  used_reg;
    logic [gap_pkg::FIFO_CNT_WIDTH-1:0]  used_next;
    logic [gap_pkg::FIFO_CNT_WIDTH-1:0]  fifo_count;
    logic [gap_pkg::COEFF_WIDTH-1:0]     rd_data;
    logic                                s3_read_valid_reg;
    logic                                item_accept;
    logic                                read_accept;
    logic                                pop;
    logic                                queue_full;

    assign cfg.ready   = 1'b1;
    assign item.ready  = (used_reg < gap_pkg::FIFO_CNT_WIDTH'(gap_pkg::FIFO_DEPTH));
    assign item_accept = item.valid && item.ready;
    assign read_accept = item_accept && (item.kind == gap_pkg::KIND_READ);
    assign pop         = result.valid && result.ready;
    assign queue_full  = (fifo_count == gap_pkg::FIFO_CNT_WIDTH'(gap_pkg::FIFO_DEPTH));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (gap_pkg::cfg_reg_t'(cfg.index))
                gap_pkg::CFG_LOG_N:
                    cfg_next.log_n = cfg.data[gap_pkg::LOGN_WIDTH-1:0];
                gap_pkg::CFG_GALOIS:
                    cfg_next.galois_element = cfg.data[gap_pkg::G_WIDTH-1:0];
                gap_pkg::CFG_MODULUS:
                    cfg_next.modulus = cfg.data[gap_pkg::COEFF_WIDTH-1:0];
                gap_pkg::CFG_NTT_MODE:
                    cfg_next.ntt_mode = cfg.data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (read_accept && !pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (pop && !read_accept)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.log_n          <= gap_pkg::LOGN_WIDTH'(12);
            cfg_reg.galois_element <= gap_pkg::G_WIDTH'(1);
            cfg_reg.modulus        <= gap_pkg::COEFF_WIDTH'(2);
            cfg_reg.ntt_mode       <= 1'b0;
            used_reg               <= '0;
            s3_read_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            used_reg          <= used_next;
            s3_read_valid_reg <= access.valid && !access.wr;
        end
    end

    gap_index u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (item_accept),
        .kind        (item.kind),
        .position    (item.position),
        .coefficient (item.coefficient),
        .cfg         (cfg_reg),
        .access      (access)
    );

    gap_store u_store (
        .clk     (clk),
        .access  (access),
        .rd_data (rd_data)
    );

    gap_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_read_valid_reg),
        .push_data (rd_data),
        .pop       (pop),
        .valid     (result.valid),
        .data      (result.result_coefficient),
        .count     (fifo_count)
    );

    `GAP_ASSERT_IMPL(a_queue_no_overflow, s3_read_valid_reg && !pop, !queue_full)
    `GAP_ASSERT_IMPL(a_credit_covers_queue, 1'b1, used_reg >= fifo_count)
    `GAP_ASSERT_NEXT(a_pop_releases_credit, pop && !read_accept, used_reg == $past(used_reg) - 1'b1)

endmodule

`default_nettype wire
